[hdl/oaht_pkg.sv]
// Shared widths, defaults and result codes for the open-addressing hash table.
// Used by the top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package oaht_pkg;

  // Table geometry
  localparam int TABLE_SIZE_DEF = 16;
  localparam int MAX_RESULTS    = 16;

  // Field widths
  localparam int KEY_W     = 64;
  localparam int KEY_BYTES = 8;
  localparam int SUM_W     = 11;   // sum of eight bytes, at most 2040
  localparam int SLOT_W    = 4;
  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 16;
  localparam int VIOL_W    = 16;

  // Request operations
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result outcome codes
  typedef logic [1:0] outcome_t;
  localparam outcome_t OUTC_INSERTED = 2'd0;
  localparam outcome_t OUTC_FULL     = 2'd1;
  localparam outcome_t OUTC_MATCH    = 2'd2;
  localparam outcome_t OUTC_NOMATCH  = 2'd3;

endpackage

[hdl/open_addressing_hash_table.sv]
// Open-addressing hash table: record memory, probe and scan sequencer, output register.
// Depends on oaht_pkg.
`timescale 1ns / 1ps

// The block takes one request at a time; in_stall stays high from acceptance until the
// request's final result has been loaded into the output register. An insert divides the
// 11-bit byte sum by TABLE_SIZE through a reciprocal multiplication, then forms the
// remainder, then probes the occupancy flags (1 to TABLE_SIZE probes), then loads the
// result. A search reads the record memory at most once per slot through its single read
// port, one slot per cycle while no new match waits on out_stall. Both also wait while
// out_stall holds back a result. A search emits one result per matching slot in slot
// order (at most 16) or one no-match result; out_last marks the final one. Occupancy
// flags clear at reset; no clearing pass is run.
module open_addressing_hash_table #(
  parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [oaht_pkg::KEY_W-1:0]  in_key_bytes,
  input  logic [oaht_pkg::DAY_W-1:0]  in_day,
  input  logic [oaht_pkg::MONTH_W-1:0] in_month,
  input  logic [oaht_pkg::YEAR_W-1:0] in_year,
  input  logic [oaht_pkg::VIOL_W-1:0] in_violation_code,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output oaht_pkg::outcome_t          out_outcome,
  output logic [oaht_pkg::SLOT_W-1:0] out_slot,
  output logic [oaht_pkg::DAY_W-1:0]  out_day,
  output logic [oaht_pkg::MONTH_W-1:0] out_month,
  output logic [oaht_pkg::YEAR_W-1:0] out_year,
  output logic [oaht_pkg::VIOL_W-1:0] out_violation,
  output logic                        out_last
);

  localparam int IDX_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int TRY_W  = $clog2(TABLE_SIZE + 1);
  localparam int CNT_W  = $clog2(oaht_pkg::MAX_RESULTS + 1);
  // Reciprocal exact for every sum below 2**SUM_W
  localparam int RECIP_SHIFT = oaht_pkg::SUM_W + IDX_W;
  localparam int PROD_W      = RECIP_SHIFT + oaht_pkg::SUM_W;

  localparam logic [PROD_W-1:0] RECIP =
    PROD_W'(((1 << RECIP_SHIFT) + TABLE_SIZE - 1) / TABLE_SIZE);
  localparam logic [oaht_pkg::SUM_W-1:0] TS_SUM = oaht_pkg::SUM_W'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
  localparam logic [TRY_W:0]   TS_WIDE   = (TRY_W + 1)'(TABLE_SIZE);
  localparam logic [TRY_W-1:0] TRY_LIMIT = TRY_W'(TABLE_SIZE);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(oaht_pkg::MAX_RESULTS - 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_HASH     = 3'd1;
  localparam logic [2:0] ST_PROBE    = 3'd2;
  localparam logic [2:0] ST_SCAN_RD  = 3'd3;
  localparam logic [2:0] ST_SCAN_CMP = 3'd4;
  localparam logic [2:0] ST_EMIT     = 3'd5;
  localparam logic [2:0] ST_MOD      = 3'd6;

  typedef struct packed {
    logic [oaht_pkg::KEY_W-1:0]   key;
    logic [oaht_pkg::DAY_W-1:0]   day;
    logic [oaht_pkg::MONTH_W-1:0] month;
    logic [oaht_pkg::YEAR_W-1:0]  year;
    logic [oaht_pkg::VIOL_W-1:0]  viol;
  } rec_t;

  typedef struct packed {
    oaht_pkg::outcome_t            outcome;
    logic [oaht_pkg::SLOT_W-1:0]   slot;
    logic [oaht_pkg::DAY_W-1:0]    day;
    logic [oaht_pkg::MONTH_W-1:0]  month;
    logic [oaht_pkg::YEAR_W-1:0]   year;
    logic [oaht_pkg::VIOL_W-1:0]   viol;
  } res_t;

  // Map a table index onto the 4-bit slot field, masking or zero-extending
  function automatic logic [oaht_pkg::SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+oaht_pkg::SLOT_W-1:0] wide;
    begin
      wide = {{oaht_pkg::SLOT_W{1'b0}}, idx};
      return wide[oaht_pkg::SLOT_W-1:0];
    end
  endfunction

  // Control registers
  logic [2:0]            state_r, state_nxt;
  logic [TABLE_SIZE-1:0] used_r, used_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Working registers
  rec_t                  req_r, req_nxt;
  logic [oaht_pkg::SUM_W-1:0] rem_r, rem_nxt;
  logic [oaht_pkg::SUM_W-1:0] quo_r, quo_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [TRY_W-1:0]      tries_r, tries_nxt;
  logic [IDX_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  res_t                  pend_r, pend_nxt;
  res_t                  out_r;
  logic                  out_last_r;

  // Record memory
  rec_t                  rec_mem [TABLE_SIZE];
  rec_t                  rd_data_r;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;

  // Datapath helpers
  logic [oaht_pkg::KEY_W-1:0] in_key_canon;
  logic [oaht_pkg::SUM_W-1:0] in_key_sum;
  logic                  key_alive;
  logic [PROD_W-1:0]     recip_prod;
  logic [oaht_pkg::SUM_W-1:0] sum_quo;
  logic [oaht_pkg::SUM_W-1:0] sum_rem;
  logic [TRY_W:0]        probe_sum;
  logic [IDX_W-1:0]      probe_pos;
  logic                  hit;
  logic                  out_free;
  logic                  emit;
  logic                  emit_last;

  // Truncate the key at its first zero byte and sum the surviving bytes
  always_comb begin
    in_key_canon = '0;
    in_key_sum   = '0;
    key_alive    = 1'b1;
    for (int i = 0; i < oaht_pkg::KEY_BYTES; i++) begin
      if (in_key_bytes[8*i +: 8] == 8'd0) begin
        key_alive = 1'b0;
      end
      if (key_alive) begin
        in_key_canon[8*i +: 8] = in_key_bytes[8*i +: 8];
        in_key_sum = in_key_sum + oaht_pkg::SUM_W'(in_key_bytes[8*i +: 8]);
      end
    end
  end

  // Quotient of the byte sum by the table size through the reciprocal
  always_comb begin
    recip_prod = PROD_W'(rem_r) * RECIP;
    sum_quo    = recip_prod[RECIP_SHIFT +: oaht_pkg::SUM_W];
  end

  // Remainder from the registered quotient
  assign sum_rem = rem_r - quo_r * TS_SUM;

  // Next probe position: previous position plus try number, wrapped once
  always_comb begin
    probe_sum = (TRY_W + 1)'(pos_r) + (TRY_W + 1)'(tries_r);
    if (probe_sum >= TS_WIDE) begin
      probe_sum = probe_sum - TS_WIDE;
    end
    probe_pos = probe_sum[IDX_W-1:0];
  end

  assign hit      = used_r[scan_idx_r] && (rd_data_r.key == req_r.key);
  assign out_free = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    pend_valid_nxt = pend_valid_r;
    req_nxt        = req_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    pos_nxt        = pos_r;
    tries_nxt      = tries_r;
    scan_idx_nxt   = scan_idx_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    mem_we         = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = scan_idx_r;
    emit           = 1'b0;
    emit_last      = 1'b1;

    case (state_r)
      ST_IDLE: begin
        // take a request
        if (in_valid) begin
          req_nxt.key   = in_key_canon;
          req_nxt.day   = in_day;
          req_nxt.month = in_month;
          req_nxt.year  = in_year;
          req_nxt.viol  = in_violation_code;
          rem_nxt       = in_key_sum;
          scan_idx_nxt  = '0;
          cnt_nxt       = '0;
          if (in_operation == oaht_pkg::OP_SEARCH) begin
            state_nxt = ST_SCAN_RD;
          end else begin
            state_nxt = ST_HASH;
          end
        end
      end

      ST_HASH: begin
        // divide the byte sum by the table size
        quo_nxt   = sum_quo;
        state_nxt = ST_MOD;
      end

      ST_MOD: begin
        // take the remainder as the home slot
        pos_nxt   = sum_rem[IDX_W-1:0];
        tries_nxt = TRY_W'(1);
        state_nxt = ST_PROBE;
      end

      ST_PROBE: begin
        // store at the first free slot, or give up after a full round of tries
        if (!used_r[pos_r]) begin
          mem_we           = 1'b1;
          used_nxt[pos_r]  = 1'b1;
          pend_nxt         = '0;
          pend_nxt.outcome = oaht_pkg::OUTC_INSERTED;
          pend_nxt.slot    = to_slot(pos_r);
          pend_valid_nxt   = 1'b1;
          state_nxt        = ST_EMIT;
        end else if (tries_r == TRY_LIMIT) begin
          pend_nxt         = '0;
          pend_nxt.outcome = oaht_pkg::OUTC_FULL;
          pend_valid_nxt   = 1'b1;
          state_nxt        = ST_EMIT;
        end else begin
          pos_nxt   = probe_pos;
          tries_nxt = tries_r + TRY_W'(1);
        end
      end

      ST_SCAN_RD: begin
        // issue the read of the first slot
        rd_en     = 1'b1;
        rd_addr   = scan_idx_r;
        state_nxt = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        // hold while a new match must push out a pending one and the output is full
        if (!(hit && pend_valid_r && !out_free)) begin
          if (hit) begin
            if (pend_valid_r) begin
              emit      = 1'b1;
              emit_last = 1'b0;
            end
            pend_nxt.outcome = oaht_pkg::OUTC_MATCH;
            pend_nxt.slot    = to_slot(scan_idx_r);
            pend_nxt.day     = rd_data_r.day;
            pend_nxt.month   = rd_data_r.month;
            pend_nxt.year    = rd_data_r.year;
            pend_nxt.viol    = rd_data_r.viol;
            pend_valid_nxt   = 1'b1;
            cnt_nxt          = cnt_r + CNT_W'(1);
          end
          if ((hit && cnt_r == CNT_LAST) || scan_idx_r == LAST_IDX) begin
            if (!hit && !pend_valid_r) begin
              pend_nxt         = '0;
              pend_nxt.outcome = oaht_pkg::OUTC_NOMATCH;
              pend_valid_nxt   = 1'b1;
            end
            state_nxt = ST_EMIT;
          end else begin
            scan_idx_nxt = scan_idx_r + IDX_W'(1);
            rd_en        = 1'b1;
            rd_addr      = scan_idx_r + IDX_W'(1);
          end
        end
      end

      ST_EMIT: begin
        // send the final result of the request
        if (out_free) begin
          emit           = 1'b1;
          emit_last      = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: load on emit, drop when taken
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    pos_r      <= pos_nxt;
    tries_r    <= tries_nxt;
    scan_idx_r <= scan_idx_nxt;
    cnt_r      <= cnt_nxt;
    pend_r     <= pend_nxt;
    if (emit) begin
      out_r      <= pend_r;
      out_last_r <= emit_last;
    end
  end

  // Record memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      rec_mem[pos_r] <= req_r;
    end
    if (rd_en) begin
      rd_data_r <= rec_mem[rd_addr];
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_outcome   = out_r.outcome;
  assign out_slot      = out_r.slot;
  assign out_day       = out_r.day;
  assign out_month     = out_r.month;
  assign out_year      = out_r.year;
  assign out_violation = out_r.viol;
  assign out_last      = out_last_r;

endmodule

[hdl/oaht_chk.sv]
// Port-level checker for the open-addressing hash table, and its bind to the top level.
// Depends on oaht_pkg and open_addressing_hash_table.
`timescale 1ns / 1ps

module oaht_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input oaht_pkg::outcome_t           out_outcome,
  input logic [oaht_pkg::SLOT_W-1:0]  out_slot,
  input logic [oaht_pkg::DAY_W-1:0]   out_day,
  input logic [oaht_pkg::MONTH_W-1:0] out_month,
  input logic [oaht_pkg::YEAR_W-1:0]  out_year,
  input logic [oaht_pkg::VIOL_W-1:0]  out_violation,
  input logic                         out_last
);

  // Busy after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request channel open right after a request was taken");

  // Idle block shows only a final result
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && out_valid) |-> out_last)
    else $error("non-final result pending while block is idle");

  // Insert, full and no-match results end their request
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome == oaht_pkg::OUTC_INSERTED ||
                   out_outcome == oaht_pkg::OUTC_FULL ||
                   out_outcome == oaht_pkg::OUTC_NOMATCH)) |-> out_last)
    else $error("single-result outcome without last flag");

  // Non-match outcomes carry zero record fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome != oaht_pkg::OUTC_MATCH) |->
      (out_day == '0 && out_month == '0 && out_year == '0 && out_violation == '0 &&
       (out_outcome == oaht_pkg::OUTC_INSERTED || out_slot == '0)))
    else $error("nonzero record fields on a non-match result");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_outcome) && $stable(out_slot) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind open_addressing_hash_table oaht_chk u_oaht_chk (.*);

[sim/tb.sv]
// Self-checking bench for the open-addressing hash table: directed and random requests.
// Depends on oaht_pkg and open_addressing_hash_table; keeps its own copy of the table.
`timescale 1ns / 1ps

module tb;

  localparam int TBL            = oaht_pkg::TABLE_SIZE_DEF;
  localparam int KEY_W          = oaht_pkg::KEY_W;
  localparam int KEY_BYTES      = oaht_pkg::KEY_BYTES;
  localparam int SLOT_W         = oaht_pkg::SLOT_W;
  localparam int DAY_W          = oaht_pkg::DAY_W;
  localparam int MONTH_W        = oaht_pkg::MONTH_W;
  localparam int YEAR_W         = oaht_pkg::YEAR_W;
  localparam int VIOL_W         = oaht_pkg::VIOL_W;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * TBL + 16;
  localparam int RAND_PER_PHASE = 84;
  localparam int NUM_BASE       = 6;
  localparam logic [KEY_W-1:0] KEY_O = 64'h4F;

  typedef struct packed {
    logic                op;
    logic [KEY_W-1:0]    key;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [VIOL_W-1:0]   viol;
  } request_t;

  typedef struct packed {
    oaht_pkg::outcome_t  outcome;
    logic [SLOT_W-1:0]   slot;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [VIOL_W-1:0]   viol;
    logic                last;
  } answer_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_operation = oaht_pkg::OP_INSERT;
  logic [KEY_W-1:0]    in_key_bytes = '0;
  logic [DAY_W-1:0]    in_day = '0;
  logic [MONTH_W-1:0]  in_month = '0;
  logic [YEAR_W-1:0]   in_year = '0;
  logic [VIOL_W-1:0]   in_violation_code = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  oaht_pkg::outcome_t  out_outcome;
  logic [SLOT_W-1:0]   out_slot;
  logic [DAY_W-1:0]    out_day;
  logic [MONTH_W-1:0]  out_month;
  logic [YEAR_W-1:0]   out_year;
  logic [VIOL_W-1:0]   out_violation;
  logic                out_last;

  open_addressing_hash_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_key_bytes      (in_key_bytes),
    .in_day            (in_day),
    .in_month          (in_month),
    .in_year           (in_year),
    .in_violation_code (in_violation_code),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_outcome       (out_outcome),
    .out_slot          (out_slot),
    .out_day           (out_day),
    .out_month         (out_month),
    .out_year          (out_year),
    .out_violation     (out_violation),
    .out_last          (out_last)
  );

  // Bench copy of the record table
  logic                slot_taken [TBL];
  logic [KEY_W-1:0]    rec_key    [TBL];
  logic [DAY_W-1:0]    rec_day    [TBL];
  logic [MONTH_W-1:0]  rec_month  [TBL];
  logic [YEAR_W-1:0]   rec_year   [TBL];
  logic [VIOL_W-1:0]   rec_viol   [TBL];

  request_t            pending_requests [$];
  answer_t             table_answers    [$];
  logic [KEY_W-1:0]    base_keys [NUM_BASE];
  request_t            next_req;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  n_accepted = 0;
  int                  n_consumed = 0;
  int                  idle_cycles = 0;
  int                  mismatches = 0;
  int                  n_insert = 0;
  int                  n_search = 0;
  int                  n_match = 0;
  int                  n_full = 0;
  int                  n_nomatch = 0;

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cut the key at its first zero byte
  function automatic logic [KEY_W-1:0] trimmed_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    bit               ended;
    r = '0;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (k[8*i +: 8] == 8'd0) ended = 1'b1;
      if (!ended) r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

  // Byte sum of the key modulo the table size
  function automatic int home_slot(input logic [KEY_W-1:0] k);
    int sum;
    sum = 0;
    for (int i = 0; i < KEY_BYTES; i++) sum += k[8*i +: 8];
    return sum % TBL;
  endfunction

  // Apply one request to the bench table and queue the answers it should produce
  task automatic apply_to_table(input request_t r);
    logic [KEY_W-1:0] k;
    int               pos;
    bit               placed;
    answer_t          a;
    answer_t          hits [$];
    k = trimmed_key(r.key);
    a = '0;
    if (r.op == oaht_pkg::OP_INSERT) begin
      n_insert++;
      pos = home_slot(k);
      placed = 1'b0;
      for (int t = 1; t <= TBL && !placed; t++) begin
        if (!slot_taken[pos]) begin
          slot_taken[pos] = 1'b1;
          rec_key[pos]    = k;
          rec_day[pos]    = r.day;
          rec_month[pos]  = r.month;
          rec_year[pos]   = r.year;
          rec_viol[pos]   = r.viol;
          a.outcome       = oaht_pkg::OUTC_INSERTED;
          a.slot          = pos[SLOT_W-1:0];
          placed          = 1'b1;
        end else begin
          pos = (pos + t) % TBL;
        end
      end
      if (!placed) begin
        a.outcome = oaht_pkg::OUTC_FULL;
        n_full++;
      end
      a.last = 1'b1;
      table_answers.push_back(a);
    end else begin
      n_search++;
      for (int s = 0; s < TBL; s++) begin
        if (slot_taken[s] && rec_key[s] == k && hits.size() < oaht_pkg::MAX_RESULTS) begin
          a.outcome = oaht_pkg::OUTC_MATCH;
          a.slot    = s[SLOT_W-1:0];
          a.day     = rec_day[s];
          a.month   = rec_month[s];
          a.year    = rec_year[s];
          a.viol    = rec_viol[s];
          a.last    = 1'b0;
          hits.push_back(a);
        end
      end
      if (hits.size() == 0) begin
        a = '0;
        a.outcome = oaht_pkg::OUTC_NOMATCH;
        a.last    = 1'b1;
        hits.push_back(a);
        n_nomatch++;
      end else begin
        hits[hits.size()-1].last = 1'b1;
        n_match += hits.size();
      end
      foreach (hits[i]) table_answers.push_back(hits[i]);
    end
  endtask

  task automatic report_field(input string name, input logic [KEY_W-1:0] want,
                              input logic [KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare one accepted result with the oldest predicted answer
  task automatic check_answer(input answer_t got);
    answer_t want;
    if (table_answers.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual outcome %0d slot %0d",
               $time, got.outcome, got.slot);
      mismatches++;
    end else begin
      want = table_answers.pop_front();
      report_field("outcome", 64'(want.outcome), 64'(got.outcome));
      report_field("slot", 64'(want.slot), 64'(got.slot));
      report_field("day", 64'(want.day), 64'(got.day));
      report_field("month", 64'(want.month), 64'(got.month));
      report_field("year", 64'(want.year), 64'(got.year));
      report_field("violation", 64'(want.viol), 64'(got.viol));
      report_field("last", 64'(want.last), 64'(got.last));
    end
  endtask

  // Nonzero key of len bytes, zero padded
  function automatic logic [KEY_W-1:0] word_key(input int len);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(255, 1));
    return k;
  endfunction

  // Same key after trimming, with random garbage past the terminator half the time
  function automatic logic [KEY_W-1:0] key_variant(input logic [KEY_W-1:0] base);
    int               len;
    bit               ended;
    logic [KEY_W-1:0] junk;
    len = 0;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (base[8*i +: 8] == 8'd0) ended = 1'b1;
      if (!ended) len++;
    end
    junk = {$urandom, $urandom};
    if (len <= 6 && $urandom_range(1)) return base | (junk << (8 * (len + 1)));
    return base;
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.op = ($urandom_range(99) < 35) ? oaht_pkg::OP_INSERT : oaht_pkg::OP_SEARCH;
    if ($urandom_range(99) < 72) r.key = key_variant(base_keys[$urandom_range(NUM_BASE-1)]);
    else r.key = {$urandom, $urandom};
    r.day   = DAY_W'($urandom_range(31));
    r.month = MONTH_W'($urandom_range(12));
    r.year  = YEAR_W'($urandom_range(16'hFFFF));
    r.viol  = VIOL_W'($urandom_range(16'hFFFF));
    return r;
  endfunction

  function automatic request_t make_req(input logic op, input logic [KEY_W-1:0] key,
                                        input int d, input int m, input int y, input int v);
    request_t r;
    r.op    = op;
    r.key   = key;
    r.day   = DAY_W'(d);
    r.month = MONTH_W'(m);
    r.year  = YEAR_W'(y);
    r.viol  = VIOL_W'(v);
    return r;
  endfunction

  task automatic wait_requests_sent();
    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
  endtask

  // Driver: present the next request on the falling edge, hold it while stalled
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || n_consumed != n_accepted) begin
        n_consumed = n_accepted;
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_valid          <= 1'b1;
          in_operation      <= next_req.op;
          in_key_bytes      <= next_req.key;
          in_day            <= next_req.day;
          in_month          <= next_req.month;
          in_year           <= next_req.year;
          in_violation_code <= next_req.viol;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: predict on each accepted request, check each accepted result, watch for hangs
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBL; i++) slot_taken[i] = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_to_table(make_req(in_operation, in_key_bytes, in_day, in_month,
                                in_year, in_violation_code));
        n_accepted++;
      end
      if (out_valid && !out_stall)
        check_answer({out_outcome, out_slot, out_day, out_month, out_year,
                      out_violation, out_last});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d answers outstanding",
                 $time, WATCHDOG_LIMIT, table_answers.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    base_keys[0] = '0;
    base_keys[1] = '1;
    base_keys[2] = KEY_O;
    base_keys[3] = 64'h4F4F;
    base_keys[4] = word_key($urandom_range(3, 1));
    base_keys[5] = word_key(KEY_BYTES);

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: empty table, empty key, extreme fields, key termination, collisions
    pending_requests.push_back(make_req(oaht_pkg::OP_SEARCH, '0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(oaht_pkg::OP_INSERT, '0, 0, 0, 0, 0));
    pending_requests.push_back(make_req(oaht_pkg::OP_SEARCH, 64'hDEADBEEF12345600,
                                        31, 12, 1, 1));
    pending_requests.push_back(make_req(oaht_pkg::OP_INSERT, '1, 31, 12, 16'hFFFF,
                                        16'hFFFF));
    pending_requests.push_back(make_req(oaht_pkg::OP_SEARCH, '1, 0, 0, 0, 0));
    pending_requests.push_back(make_req(oaht_pkg::OP_INSERT, 64'hA5C37E191B2C004F,
                                        1, 1, 2024, 7));
    pending_requests.push_back(make_req(oaht_pkg::OP_INSERT, KEY_O, 15, 6, 16'h8000,
                                        16'h0001));
    pending_requests.push_back(make_req(oaht_pkg::OP_SEARCH, 64'h123456004F, 0, 0, 0, 0));
    pending_requests.push_back(make_req(oaht_pkg::OP_SEARCH, 64'h0123456789ABCDEF,
                                        0, 0, 0, 0));
    pending_requests.push_back(make_req(oaht_pkg::OP_INSERT, 64'h4F4F, 16, 8, 16'h5555,
                                        16'hAAAA));
    pending_requests.push_back(make_req(oaht_pkg::OP_INSERT, 64'h08, 2, 3, 16'h00FF,
                                        16'hFF00));
    pending_requests.push_back(make_req(oaht_pkg::OP_SEARCH, 64'h08, 0, 0, 0, 0));

    // Hold the sender until every answer of the directed part is back
    wait_requests_sent();
    while (table_answers.size() != 0) @(posedge clk);

    // Random: sender idles lightly, receiver heavily; then swapped; then no idling
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 66 : 0;
      recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 21 : 0;
      for (int i = 0; i < RAND_PER_PHASE; i++) pending_requests.push_back(random_request());
      wait_requests_sent();
    end

    // Drain outstanding answers, then watch a while for stray results
    while (table_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d inserts (%0d hit a full table) and %0d searches",
             n_insert, n_full, n_search);
    $display("Checked %0d match results and %0d no-match results, %0d mismatches",
             n_match, n_nomatch, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/oaht_pkg.sv
hdl/open_addressing_hash_table.sv
hdl/oaht_chk.sv
sim/tb.sv
